// File: hdl/msr_pkg.sv
// Shared types, widths and conversion functions for the motor speed ramp.
`default_nettype none
package msr_pkg;

  localparam int PCT_W  = 7;
  localparam int DUTY_W = 8;
  localparam int RT_W   = 16;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_FIN  = 3'b100
  } msr_state_t;

  // Multiply/divide unit phases.
  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_MUL  = 3'b010,
    U_DIV  = 3'b100
  } msr_phase_t;

  // Target duty = min(pct,100)*255/100, truncated. The divide by 100 is a
  // multiply by 5243/2^19, which is exact for every product that can occur.
  function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    logic [14:0]      x;
    logic [27:0]      y;
    p = (pct > PCT_FULL) ? PCT_FULL : pct;
    x = {p, 8'd0} - 15'(p);
    y = 28'(x) * 28'd5243;
    return y[26:19];
  endfunction

  // Percent = (duty*100 + 127)/255, with x/255 = (x + (x>>8) + 1) >> 8.
  function automatic logic [PCT_W-1:0] duty_to_pct(input logic [DUTY_W-1:0] duty);
    logic [14:0] x;
    logic [15:0] s;
    x = 15'(duty) * 15'd100 + 15'd127;
    s = 16'(x) + 16'(x[14:8]) + 16'd1;
    return s[14:8];
  endfunction

endpackage
`default_nettype wire

// File: hdl/msr_muldiv.sv
// Bit-serial multiply of elapsed time by the duty span, then restoring
// divide by the ramp length, one bit per cycle.
`default_nettype none
module msr_muldiv #(
  parameter int TIME_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [TIME_BITS-1:0]             elapsed,
  input  wire logic [msr_pkg::DUTY_W-1:0]       span,
  input  wire logic [TIME_BITS-1:0]             length,
  output logic                                  done,
  output logic [msr_pkg::DUTY_W-1:0]            quo
);
  import msr_pkg::*;

  localparam int ACC_W = TIME_BITS + DUTY_W;

  msr_phase_t            phase;
  logic [2:0]            cnt;
  logic [DUTY_W-1:0]     mplier;
  logic [ACC_W-1:0]      acc;
  logic [TIME_BITS:0]    top;
  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS-1:0]  hi_next;

  // One restoring step: the high part of acc is the partial remainder and
  // always stays below the length, since the quotient fits in eight bits.
  always_comb begin
    top   = {acc[ACC_W-1:DUTY_W], acc[DUTY_W-1]};
    trial = top - {1'b0, length};
    hi_next = trial[TIME_BITS] ? top[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (phase == U_DIV) && (cnt == 3'd7);
      unique case (phase)
        U_IDLE: begin
          if (start) begin
            phase <= U_MUL;
            cnt   <= '0;
          end
        end
        U_MUL: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            phase <= U_DIV;
          end
        end
        U_DIV: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            phase <= U_IDLE;
          end
        end
        default: phase <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      U_IDLE: begin
        if (start) begin
          acc    <= '0;
          mplier <= span;
        end
      end
      U_MUL: begin
        acc    <= {acc[ACC_W-2:0], 1'b0} + (mplier[DUTY_W-1] ? ACC_W'(elapsed) : '0);
        mplier <= {mplier[DUTY_W-2:0], 1'b0};
      end
      U_DIV: begin
        acc <= {hi_next, acc[DUTY_W-2:0], ~trial[TIME_BITS]};
      end
      default: ;
    endcase
  end

  assign quo = acc[DUTY_W-1:0];

endmodule
`default_nettype wire

// File: hdl/motor_speed_ramp_hbridge.sv
// Top level of the H-bridge speed ramp driver.
// Usage: items enter on the s_axis channel. s_axis_tuser selects the kind
// of item: 0 is a one-millisecond tick, 1 sets a new target speed and ramp
// time. Each item gives exactly one result item on m_axis: PWM duty, bridge
// input levels, duty in percent and a ramp busy flag.
// Sequence: a set item, a tick that does not move the duty, or a tick on a
// ramp of zero length goes from acceptance through S_FIN to the output
// register. A tick that moves a ramp of nonzero length first runs a
// bit-serial multiply of elapsed time by the duty span, then a restoring
// divide by the ramp length, one quotient bit per cycle. One item is worked
// on at a time: s_axis_tready stays low until its result is registered.
// The result sits in an output register; a new item is accepted while it
// waits, but the next result is held back until the receiver takes the
// previous one, so a stall on m_axis eventually stalls s_axis.
// Reset (rst, synchronous) clears the duty, disarms the ramp, sets the
// ramp length to 1000 ms (all ones if TIME_BITS is too narrow) and drops
// m_axis_tvalid.
`default_nettype none
module motor_speed_ramp_hbridge #(
  parameter int TIME_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: speed_percent[6:0], ramp_time_ms[22:7], motor_enable[23],
  // dir_reverse[24], zero fill [31:25]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: req_type[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: pwm_duty[7:0], bridge_in1[8], bridge_in2[9], duty_percent[16:10],
  // ramp_busy[17], zero fill [23:18]
  output logic [23:0]      m_axis_tdata
);
  import msr_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] LEN_RESET =
    (TIME_BITS >= 10) ? TIME_BITS'(1000) : {TIME_BITS{1'b1}};

  msr_state_t            state;
  logic [DUTY_W-1:0]     duty_now;
  logic [DUTY_W-1:0]     ramp_start_duty;
  logic [DUTY_W-1:0]     ramp_goal_duty;
  logic [TIME_BITS-1:0]  ramp_length;
  logic [TIME_BITS-1:0]  ramp_elapsed;
  logic                  ramp_armed;
  logic                  ramp_rising;
  logic                  held_in1;
  logic                  held_in2;
  logic                  item_en;

  logic [PCT_W-1:0]      in_pct;
  logic [RT_W-1:0]       in_time;
  logic                  in_en;
  logic                  in_rev;
  logic                  accept;
  logic                  pending;
  logic [TIME_BITS-1:0]  time_sat;
  logic [TIME_BITS-1:0]  elapsed_next;
  logic [DUTY_W-1:0]     new_goal;
  logic [DUTY_W-1:0]     span;
  logic                  unit_start;
  logic                  unit_done;
  logic [DUTY_W-1:0]     unit_quo;
  logic                  out_free;

  assign in_pct  = s_axis_tdata[6:0];
  assign in_time = s_axis_tdata[22:7];
  assign in_en   = s_axis_tdata[23];
  assign in_rev  = s_axis_tdata[24];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    if (!ramp_armed) begin
      pending = 1'b0;
    end else if (ramp_rising) begin
      pending = duty_now < ramp_goal_duty;
    end else begin
      pending = ramp_goal_duty < duty_now;
    end
  end

  always_comb begin
    if (32'(in_time) > 32'(TIME_MAX)) begin
      time_sat = TIME_MAX;
    end else begin
      time_sat = TIME_BITS'(in_time);
    end
    elapsed_next = (ramp_elapsed < ramp_length) ? ramp_elapsed + TIME_BITS'(1)
                                                : ramp_length;
    new_goal     = pct_to_duty(in_pct);
    span         = ramp_rising ? ramp_goal_duty - ramp_start_duty
                               : ramp_start_duty - ramp_goal_duty;
  end

  // The tick's elapsed update is written on acceptance, so the unit sees it
  // on the following cycle.
  assign unit_start = accept && !s_axis_tuser && in_en && pending && (ramp_length != '0);

  msr_muldiv #(
    .TIME_BITS(TIME_BITS)
  ) u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .elapsed (ramp_elapsed),
    .span    (span),
    .length  (ramp_length),
    .done    (unit_done),
    .quo     (unit_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      duty_now        <= '0;
      ramp_start_duty <= '0;
      ramp_goal_duty  <= '0;
      ramp_length     <= LEN_RESET;
      ramp_elapsed    <= '0;
      ramp_armed      <= 1'b0;
      ramp_rising     <= 1'b0;
      held_in1        <= 1'b0;
      held_in2        <= 1'b0;
      item_en         <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_en <= in_en;
            if (in_en) begin
              held_in1 <= !in_rev;
              held_in2 <= in_rev;
            end
            if (s_axis_tuser) begin
              state           <= S_FIN;
              ramp_length     <= time_sat;
              ramp_start_duty <= duty_now;
              ramp_goal_duty  <= new_goal;
              if (new_goal != duty_now) begin
                ramp_elapsed <= '0;
                ramp_armed   <= 1'b1;
                ramp_rising  <= duty_now < new_goal;
              end
            end else begin
              ramp_elapsed <= elapsed_next;
              if (in_en && pending && ramp_length == '0) begin
                duty_now <= ramp_goal_duty;
              end
              if (unit_start) begin
                state <= S_WAIT;
              end else begin
                state <= S_FIN;
              end
            end
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            duty_now <= ramp_rising ? ramp_start_duty + unit_quo
                                    : ramp_start_duty - unit_quo;
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_axis_tdata <= {6'd0, pending, duty_to_pct(duty_now), held_in2, held_in1,
                       item_en ? duty_now : 8'd0};
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the H-bridge speed ramp driver.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msr_pkg::*;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SET  = 1'b1
  } req_t;

  // One input item, in the order the fields are listed for the block.
  typedef struct packed {
    req_t              req;
    logic [PCT_W-1:0]  pct;
    logic [RT_W-1:0]   rt;
    logic              en;
    logic              rev;
  } speed_cmd_t;

  // One result item.
  typedef struct packed {
    logic [DUTY_W-1:0] pwm;
    logic              in1;
    logic              in2;
    logic [PCT_W-1:0]  pct;
    logic              busy;
  } bridge_drive_t;

  typedef struct packed {
    speed_cmd_t    cmd;
    logic          typed;
    bridge_drive_t want;
  } plan_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic MODEL = 1'b0;
  localparam bridge_drive_t NO_DRIVE = '0;
  localparam int PLAN_LEN = 24;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CMD_W = $bits(speed_cmd_t);
  // Longest quiet stretch of a correct run: the longest sender gap plus the
  // longest receiver stall plus the ramp multiply and divide, with a wide margin.
  localparam int STALL_LIMIT = 3000;

  // Directed items. Only the opening rows carry a typed-in result; the rest
  // are checked against the ramp predictor.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    {{REQ_TICK, 7'd0,   16'd0,     1'b0, 1'b0}, TYPED, {8'd0,   1'b0, 1'b0, 7'd0,   1'b0}},
    {{REQ_SET,  7'd127, 16'd0,     1'b1, 1'b0}, TYPED, {8'd0,   1'b1, 1'b0, 7'd0,   1'b1}},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, TYPED, {8'd255, 1'b1, 1'b0, 7'd100, 1'b0}},
    {{REQ_SET,  7'd0,   16'd65535, 1'b1, 1'b1}, TYPED, {8'd255, 1'b0, 1'b1, 7'd100, 1'b1}},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b1}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b0, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_SET,  7'd100, 16'd3,     1'b0, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_SET,  7'd50,  16'd4,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_SET,  7'd101, 16'd10,    1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b0, 1'b1}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b0, 1'b1}, MODEL, NO_DRIVE},
    {{REQ_SET,  7'd50,  16'd1,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_SET,  7'd10,  16'd2,     1'b1, 1'b1}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b1}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b1}, MODEL, NO_DRIVE},
    {{REQ_SET,  7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd0,   16'd0,     1'b1, 1'b0}, MODEL, NO_DRIVE},
    {{REQ_TICK, 7'd127, 16'd65535, 1'b1, 1'b1}, MODEL, NO_DRIVE}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_ready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [23:0] m_axis_tdata;

  // Ramp state as the predictor tracks it.
  logic [DUTY_W-1:0] cur_duty;
  logic [DUTY_W-1:0] start_duty;
  logic [DUTY_W-1:0] goal_duty;
  logic [RT_W-1:0]   len_ms;
  logic [RT_W-1:0]   elapsed_ms;
  logic              armed;
  logic              rising;
  logic              pin1;
  logic              pin2;

  bridge_drive_t due_q [$];
  int            items_sent = 0;
  int            fail_cnt = 0;
  int            tx_calm = 0;
  int            rx_calm = 0;

  motor_speed_ramp_hbridge u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic ramp_pending();
    if (!armed) return 1'b0;
    return rising ? (cur_duty < goal_duty) : (goal_duty < cur_duty);
  endfunction

  // Advances the ramp state by one item and returns the result it gives.
  function automatic bridge_drive_t next_drive(input speed_cmd_t c);
    bridge_drive_t    r;
    logic [PCT_W-1:0] p;
    longint           span;
    longint           nxt;
    if (c.req == REQ_SET) begin
      p = (c.pct > 7'd100) ? 7'd100 : c.pct;
      len_ms = c.rt;
      start_duty = cur_duty;
      goal_duty = DUTY_W'((int'(p) * 255) / 100);
      if (goal_duty != cur_duty) begin
        elapsed_ms = '0;
        armed = 1'b1;
        rising = cur_duty < goal_duty;
      end
    end else begin
      if (elapsed_ms < len_ms) elapsed_ms++;
      if (elapsed_ms > len_ms) elapsed_ms = len_ms;
      if (c.en && ramp_pending()) begin
        if (len_ms == 0) begin
          cur_duty = goal_duty;
        end else begin
          span = longint'(goal_duty) - longint'(start_duty);
          nxt = longint'(start_duty) + (longint'(elapsed_ms) * span) / longint'(len_ms);
          if (nxt < 0) nxt = 0;
          if (nxt > 255) nxt = 255;
          cur_duty = nxt[DUTY_W-1:0];
        end
      end
    end
    if (c.en) begin
      pin1 = ~c.rev;
      pin2 = c.rev;
    end
    r.pwm = c.en ? cur_duty : '0;
    r.in1 = pin1;
    r.in2 = pin2;
    r.pct = PCT_W'((int'(cur_duty) * 100 + 127) / 255);
    r.busy = ramp_pending();
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 100) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_cmd(input speed_cmd_t c, input logic typed, input bridge_drive_t want);
    bridge_drive_t d;
    int            gap;
    s_valid <= 1'b1;
    s_data <= {7'd0, c.rev, c.en, c.rt, c.pct};
    s_user <= c.req;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    d = next_drive(c);
    due_q.push_back(typed ? want : d);
    items_sent++;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (due_q.size() != 0);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
    end
  endtask

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      stall = pick_gap(rx_calm);
      if (stall == 0) begin
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bridge_drive_t got;
    bridge_drive_t w;
    if (!rst && m_axis_tvalid === 1'b1 && m_ready) begin
      got.pwm = m_axis_tdata[7:0];
      got.in1 = m_axis_tdata[8];
      got.in2 = m_axis_tdata[9];
      got.pct = m_axis_tdata[16:10];
      got.busy = m_axis_tdata[17];
      if (due_q.size() == 0) begin
        fail_cnt++;
        $display("%0t ns: result %h arrived with nothing expected", $realtime, m_axis_tdata);
      end else begin
        w = due_q.pop_front();
        compare_field("pwm_duty", w.pwm, got.pwm);
        compare_field("bridge_in1", w.in1, got.in1);
        compare_field("bridge_in2", w.in2, got.in2);
        compare_field("duty_percent", w.pct, got.pct);
        compare_field("ramp_busy", w.busy, got.busy);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_valid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_ready))
        idle = 0;
      else
        idle++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    speed_cmd_t c;
    int         n;
    cur_duty = '0;
    start_duty = '0;
    goal_duty = '0;
    len_ms = RT_W'(1000);
    elapsed_ms = '0;
    armed = 1'b0;
    rising = 1'b0;
    pin1 = 1'b0;
    pin2 = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < PLAN_LEN; k++)
      send_cmd(PLAN[k].cmd, PLAN[k].typed, PLAN[k].want);
    hold_until_drained();

    // Mostly a set followed by enough ticks to finish its ramp, with some
    // disabled ticks and direction flips; the rest is unstructured noise.
    while (items_sent < PLAN_LEN + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        c.req = REQ_SET;
        c.pct = PCT_W'($urandom_range(0, 127));
        c.rt = ($urandom_range(0, 19) == 0) ? RT_W'($urandom) : RT_W'($urandom_range(0, 24));
        c.en = $urandom_range(0, 7) != 0;
        c.rev = 1'($urandom_range(0, 1));
        send_cmd(c, MODEL, NO_DRIVE);
        n = (c.rt <= 24) ? int'(c.rt) + $urandom_range(0, 4) : $urandom_range(1, 30);
        for (int k = 0; k < n; k++) begin
          c.req = REQ_TICK;
          c.pct = PCT_W'($urandom);
          c.rt = RT_W'($urandom);
          c.en = $urandom_range(0, 9) != 0;
          if ($urandom_range(0, 9) == 0) c.rev = ~c.rev;
          send_cmd(c, MODEL, NO_DRIVE);
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          c = CMD_W'($urandom);
          send_cmd(c, MODEL, NO_DRIVE);
        end
      end
      if ($urandom_range(0, 59) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
